/* sv/xrs_pkg.sv */
// ============================================================================
// xrs_pkg
// Shared types and constants of the xoroshiro128+ random source
// ============================================================================
`default_nettype none

package xrs_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned HALF_W      = DATA_W / 2;
    localparam int unsigned IN_TDATA_W  = 136;
    localparam int unsigned OUT_TDATA_W = 64;

    // splitmix64 constants
    localparam logic [DATA_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [DATA_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [DATA_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned MIX_SH1 = 30;
    localparam int unsigned MIX_SH2 = 27;
    localparam int unsigned MIX_SH3 = 31;

    // xoroshiro128+ step
    localparam int unsigned ROT_A   = 55;
    localparam int unsigned SHIFT_B = 14;
    localparam int unsigned ROT_C   = 36;

    // divider and multiplier sequencing
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned MUL_PH_W  = 2;

    localparam logic [MUL_PH_W-1:0] MUL_PH_LL  = 2'd0;
    localparam logic [MUL_PH_W-1:0] MUL_PH_LH  = 2'd1;
    localparam logic [MUL_PH_W-1:0] MUL_PH_HL  = 2'd2;
    localparam logic [MUL_PH_W-1:0] MUL_PH_ACC = 2'd3;

    localparam logic MODE_RAW     = 1'b0;
    localparam logic MODE_BOUNDED = 1'b1;

    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;
    localparam logic [1:0] WSEL_64 = 2'd3;

    typedef struct packed {
        logic                z_load;
        logic                word;
        logic                mul_en;
        logic [MUL_PH_W-1:0] mul_phase;
        logic                mul_b;
        logic                z_mix;
        logic                store_en;
        logic                latch;
        logic                draw;
        logic                div_step;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic empty;
    } t_dp_status;

    typedef enum logic [7:0] {
        S_SEED_LOAD  = 8'b0000_0001,
        S_SEED_MUL   = 8'b0000_0010,
        S_SEED_MIX   = 8'b0000_0100,
        S_SEED_STORE = 8'b0000_1000,
        S_IDLE       = 8'b0001_0000,
        S_DRAW       = 8'b0010_0000,
        S_DIV        = 8'b0100_0000,
        S_OUT        = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

/* sv/xrs_datapath.sv */
// ============================================================================
// xrs_datapath
// State words, splitmix64 seeding unit, xoroshiro step, bit-serial divider
// ============================================================================
`default_nettype none

module xrs_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_seed_we,
    input  wire logic [xrs_pkg::DATA_W-1:0]         i_seed_wdata,
    input  wire logic [xrs_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    input  wire xrs_pkg::t_dp_cmd                   i_cmd,
    output xrs_pkg::t_dp_status                     o_status,
    output logic [xrs_pkg::OUT_TDATA_W-1:0]         o_out_tdata
);

    localparam int unsigned W = xrs_pkg::DATA_W;
    localparam int unsigned H = xrs_pkg::HALF_W;

    logic [W-1:0] r_seed;
    logic [W-1:0] r_state_lo, r_state_hi;
    logic [W-1:0] r_z, r_prod, r_acc;
    logic         r_mode;
    logic [1:0]   r_sel;
    logic [W-1:0] r_lo, r_hi;
    logic [W-1:0] r_draw;
    logic [W-1:0] r_rem, r_dvd, r_dvs;
    logic [W-1:0] r_out;

    logic [W-1:0] in_mask;
    logic [W-1:0] seed_sum;
    logic [W-1:0] mul_c;
    logic [H-1:0] mul_x, mul_k;
    logic [W-1:0] store_val;
    logic [W-1:0] draw_sum, draw_b, next_lo, next_hi;
    logic         empty;
    logic [W:0]   div_trial;
    logic         div_ge;
    logic [W-1:0] res;

    always_comb begin
        case (i_in_tdata[2:1])
            xrs_pkg::WSEL_8:  in_mask = {{(W-8){1'b0}}, {8{1'b1}}};
            xrs_pkg::WSEL_16: in_mask = {{(W-16){1'b0}}, {16{1'b1}}};
            xrs_pkg::WSEL_32: in_mask = {{(W-32){1'b0}}, {32{1'b1}}};
            default:          in_mask = {W{1'b1}};
        endcase
    end

    // splitmix64 pieces
    assign seed_sum  = r_seed + xrs_pkg::GOLDEN_GAMMA + {{(W-1){1'b0}}, i_cmd.word};
    assign mul_c     = i_cmd.mul_b ? xrs_pkg::MIX_MUL_B : xrs_pkg::MIX_MUL_A;
    assign mul_x     = (i_cmd.mul_phase == xrs_pkg::MUL_PH_HL) ? r_z[W-1:H] : r_z[H-1:0];
    assign mul_k     = (i_cmd.mul_phase == xrs_pkg::MUL_PH_LH) ? mul_c[W-1:H] : mul_c[H-1:0];
    assign store_val = r_acc ^ (r_acc >> xrs_pkg::MIX_SH3);

    // xoroshiro128+ step
    assign draw_sum = r_state_lo + r_state_hi;
    assign draw_b   = r_state_lo ^ r_state_hi;
    assign next_lo  = ((r_state_lo << xrs_pkg::ROT_A) | (r_state_lo >> (W - xrs_pkg::ROT_A)))
                      ^ draw_b ^ (draw_b << xrs_pkg::SHIFT_B);
    assign next_hi  = (draw_b << xrs_pkg::ROT_C) | (draw_b >> (W - xrs_pkg::ROT_C));

    assign empty = (r_hi <= r_lo);

    // restoring divider, one quotient bit per step
    assign div_trial = {r_rem, r_dvd[W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dvs});

    always_comb begin
        if (r_mode == xrs_pkg::MODE_RAW) begin
            case (r_sel)
                xrs_pkg::WSEL_8:  res = {{(W-8){1'b0}}, r_draw[W-1:W-8]};
                xrs_pkg::WSEL_16: res = {{(W-16){1'b0}}, r_draw[W-1:W-16]};
                xrs_pkg::WSEL_32: res = {{(W-32){1'b0}}, r_draw[W-1:W-32]};
                default:          res = r_draw;
            endcase
        end else if (empty) begin
            res = r_lo;
        end else begin
            res = r_rem + r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_seed_we) begin
            r_seed <= i_seed_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.z_load) begin
            r_z <= seed_sum ^ (seed_sum >> xrs_pkg::MIX_SH1);
        end else if (i_cmd.z_mix) begin
            r_z <= r_acc ^ (r_acc >> xrs_pkg::MIX_SH2);
        end

        if (i_cmd.mul_en) begin
            r_prod <= mul_x * mul_k;
            case (i_cmd.mul_phase)
                xrs_pkg::MUL_PH_LH:  r_acc <= r_prod;
                xrs_pkg::MUL_PH_HL,
                xrs_pkg::MUL_PH_ACC: r_acc <= r_acc + {r_prod[H-1:0], {H{1'b0}}};
                default:             r_acc <= r_acc;
            endcase
        end

        if (i_cmd.store_en) begin
            if (i_cmd.word) begin
                r_state_hi <= store_val;
            end else begin
                r_state_lo <= store_val;
            end
        end else if (i_cmd.draw && (r_mode == xrs_pkg::MODE_RAW || !empty)) begin
            r_state_lo <= next_lo;
            r_state_hi <= next_hi;
        end

        if (i_cmd.latch) begin
            r_mode <= i_in_tdata[0];
            r_sel  <= i_in_tdata[2:1];
            r_lo   <= i_in_tdata[66:3] & in_mask;
            r_hi   <= i_in_tdata[130:67] & in_mask;
        end

        if (i_cmd.draw) begin
            r_draw <= draw_sum;
            r_dvd  <= draw_sum;
            r_dvs  <= r_hi - r_lo;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= div_ge ? W'(div_trial - {1'b0, r_dvs}) : div_trial[W-1:0];
        end

        if (i_cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_status.mode  = r_mode;
    assign o_status.empty = empty;
    assign o_out_tdata    = r_out;

endmodule

`default_nettype wire

/* sv/xrs_ctrl.sv */
// ============================================================================
// xrs_ctrl
// Sequencer for seeding, draw, division and result hand-off
// ============================================================================
`default_nettype none

module xrs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_seed_we,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    input  wire xrs_pkg::t_dp_status  i_status,
    output xrs_pkg::t_dp_cmd          o_cmd
);

    xrs_pkg::t_state r_state, n_state;
    logic [xrs_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_word, n_word;
    logic r_pass, n_pass;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic bounded;

    assign out_free = !r_out_valid || i_out_ready;
    assign bounded  = (i_status.mode == xrs_pkg::MODE_BOUNDED) && !i_status.empty;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.word      = r_word;
        o_cmd.mul_phase = r_cnt[xrs_pkg::MUL_PH_W-1:0];
        o_cmd.mul_b     = r_pass;

        case (r_state)
            xrs_pkg::S_SEED_LOAD: begin
                o_cmd.z_load = 1'b1;
                n_pass  = 1'b0;
                n_cnt   = '0;
                n_state = xrs_pkg::S_SEED_MUL;
            end
            xrs_pkg::S_SEED_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[xrs_pkg::MUL_PH_W-1:0] == xrs_pkg::MUL_PH_ACC) begin
                    n_state = r_pass ? xrs_pkg::S_SEED_STORE : xrs_pkg::S_SEED_MIX;
                end
            end
            xrs_pkg::S_SEED_MIX: begin
                o_cmd.z_mix = 1'b1;
                n_pass  = 1'b1;
                n_cnt   = '0;
                n_state = xrs_pkg::S_SEED_MUL;
            end
            xrs_pkg::S_SEED_STORE: begin
                o_cmd.store_en = 1'b1;
                n_word  = 1'b1;
                n_state = r_word ? xrs_pkg::S_IDLE : xrs_pkg::S_SEED_LOAD;
            end
            xrs_pkg::S_IDLE: begin
                o_in_ready = !i_seed_we;
                if (i_in_valid && !i_seed_we) begin
                    o_cmd.latch = 1'b1;
                    n_state = xrs_pkg::S_DRAW;
                end
            end
            xrs_pkg::S_DRAW: begin
                o_cmd.draw = 1'b1;
                n_cnt   = '0;
                n_state = bounded ? xrs_pkg::S_DIV : xrs_pkg::S_OUT;
            end
            xrs_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == xrs_pkg::CNT_W'(xrs_pkg::DIV_STEPS - 1)) begin
                    n_state = xrs_pkg::S_OUT;
                end
            end
            xrs_pkg::S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = xrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = xrs_pkg::S_SEED_LOAD;
            end
        endcase

        // a seed write restarts the seeding sequence
        if (i_seed_we) begin
            n_word  = 1'b0;
            n_state = xrs_pkg::S_SEED_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xrs_pkg::S_SEED_LOAD;
            r_cnt       <= '0;
            r_word      <= 1'b0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_word      <= n_word;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* sv/xoroshiro_random_source_unit.sv */
// ============================================================================
// xoroshiro_random_source_unit
// xoroshiro128+ random source with splitmix64 seeding and bounded draws
// ============================================================================
// usage
//   s_axis carries one request item, m_axis returns one 64-bit value per item.
//   i_seed_we / i_seed_wdata load a new seed; both state words are rebuilt
//   through two splitmix64 rounds (seed and seed+1), during which
//   s_axis_tready is low. the same seeding with seed 0 runs after reset.
//   an accepted item is latched and drawn; a raw draw or an empty range
//   then goes straight to the output register, while a bounded draw
//   first runs the restoring divider, which retires one remainder bit per
//   cycle.
//   one item is in work at a time; a new item is taken once the previous
//   result has moved into the output register.
//   when m_axis_tready is low the result waits in the output register and a
//   following item still runs; it then holds until that register frees up.
// ============================================================================
`default_nettype none

module xoroshiro_random_source_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_seed_we,
    input  wire logic [xrs_pkg::DATA_W-1:0]          i_seed_wdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // mode, width_select[1:0], range_min[63:0], range_max[63:0], zero pad
    input  wire logic [xrs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // value[63:0]
    output logic [xrs_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    xrs_pkg::t_dp_cmd    cmd;
    xrs_pkg::t_dp_status status;

    xrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (i_seed_we),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    xrs_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_in_tdata   (s_axis_tdata),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_tdata  (m_axis_tdata)
    );

    a_cmd_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.z_load, cmd.mul_en, cmd.z_mix, cmd.store_en, cmd.latch,
                  cmd.draw, cmd.div_step, cmd.out_load}))
        else $error("datapath commands overlap");

    a_accept_draws : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> cmd.draw)
        else $error("accepted item not drawn in the next cycle");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    a_load_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* verif/xoroshiro_random_source_unit_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// xoroshiro_random_source_unit_tb
// Self-checking bench for the xoroshiro128+ random source
// ============================================================================
// requests stream in on s_axis and values come back on m_axis. a model
// of the generator (splitmix64 seeding, xoroshiro128+ step, raw and bounded
// draws) predicts each value at accept time and the monitor compares it with
// the oldest prediction. the seed is rewritten between phases while the unit
// is drained, covering zero, all ones, the top bit alone and random seeds.
// both sides stall at random, except during one quiet phase.
// ============================================================================

module xoroshiro_random_source_unit_tb;

    typedef struct packed {
        logic [xrs_pkg::DATA_W-1:0] rmax;
        logic [xrs_pkg::DATA_W-1:0] rmin;
        logic [1:0]                 wsel;
        logic                       mode;
    } t_draw_req;

    localparam int unsigned PAD_W = xrs_pkg::IN_TDATA_W - $bits(t_draw_req);

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_seed_we = 1'b0;
    logic [xrs_pkg::DATA_W-1:0]      i_seed_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [xrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [xrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    t_draw_req                  draw_req_q[$];
    logic [xrs_pkg::DATA_W-1:0] exp_value_q[$];
    t_draw_req                  cur_req;
    logic [xrs_pkg::DATA_W-1:0] gen_lo;
    logic [xrs_pkg::DATA_W-1:0] gen_hi;
    logic              no_idle = 1'b0;
    int                fail_count = 0;
    int                n_raw = 0;
    int                n_bounded = 0;
    int                n_empty = 0;
    int                n_seeds = 0;
    int                n_checked = 0;

    xoroshiro_random_source_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // generator model
    function automatic logic [xrs_pkg::DATA_W-1:0] splitmix(
        input logic [xrs_pkg::DATA_W-1:0] x);
        logic [xrs_pkg::DATA_W-1:0] z;
        z = x;
        z = (z ^ (z >> xrs_pkg::MIX_SH1)) * xrs_pkg::MIX_MUL_A;
        z = (z ^ (z >> xrs_pkg::MIX_SH2)) * xrs_pkg::MIX_MUL_B;
        return z ^ (z >> xrs_pkg::MIX_SH3);
    endfunction

    function automatic logic [xrs_pkg::DATA_W-1:0] rotl(
        input logic [xrs_pkg::DATA_W-1:0] x, input int k);
        return (x << k) | (x >> (xrs_pkg::DATA_W - k));
    endfunction

    function automatic void reseed(input logic [xrs_pkg::DATA_W-1:0] s);
        gen_lo = splitmix(s + xrs_pkg::GOLDEN_GAMMA);
        gen_hi = splitmix(s + xrs_pkg::GOLDEN_GAMMA + 64'd1);
    endfunction

    function automatic logic [xrs_pkg::DATA_W-1:0] next_draw();
        logic [xrs_pkg::DATA_W-1:0] a;
        logic [xrs_pkg::DATA_W-1:0] b;
        logic [xrs_pkg::DATA_W-1:0] sum;
        a = gen_lo;
        b = gen_hi;
        sum = a + b;
        b = b ^ a;
        gen_lo = rotl(a, xrs_pkg::ROT_A) ^ b ^ (b << xrs_pkg::SHIFT_B);
        gen_hi = rotl(b, xrs_pkg::ROT_C);
        return sum;
    endfunction

    function automatic logic [xrs_pkg::DATA_W-1:0] predict_value(input t_draw_req r);
        logic [xrs_pkg::DATA_W-1:0] mask;
        logic [xrs_pkg::DATA_W-1:0] lo;
        logic [xrs_pkg::DATA_W-1:0] hi;
        logic [xrs_pkg::DATA_W-1:0] res;
        case (r.wsel)
            xrs_pkg::WSEL_8:  mask = 64'hFF;
            xrs_pkg::WSEL_16: mask = 64'hFFFF;
            xrs_pkg::WSEL_32: mask = 64'hFFFF_FFFF;
            default:          mask = '1;
        endcase
        if (r.mode == xrs_pkg::MODE_RAW) begin
            res = next_draw() >> (xrs_pkg::DATA_W - (8 << r.wsel));
            n_raw++;
        end else begin
            lo = r.rmin & mask;
            hi = r.rmax & mask;
            if (hi <= lo) begin
                res = lo;
                n_empty++;
            end else begin
                res = (next_draw() % (hi - lo)) + lo;
                n_bounded++;
            end
        end
        return res & mask;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            reseed('0);
        end else begin
            if (i_seed_we) begin
                reseed(i_seed_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                exp_value_q.push_back(predict_value(cur_req));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (draw_req_q.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
                    cur_req = draw_req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{PAD_W{1'b0}}, cur_req};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [xrs_pkg::DATA_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_value_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item: value %h", m_axis_tdata);
                end else begin
                    want = exp_value_q.pop_front();
                    n_checked++;
                    if (m_axis_tdata !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("value mismatch: expected %h, got %h", want, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= no_idle || $urandom_range(99) >= 10;
        end
    end

    task automatic add_req(input logic mode, input logic [1:0] wsel,
                           input logic [xrs_pkg::DATA_W-1:0] rmin,
                           input logic [xrs_pkg::DATA_W-1:0] rmax);
        t_draw_req r;
        r.mode = mode;
        r.wsel = wsel;
        r.rmin = rmin;
        r.rmax = rmax;
        draw_req_q.push_back(r);
    endtask

    task automatic add_random(input int n);
        logic [xrs_pkg::DATA_W-1:0] lo;
        logic [xrs_pkg::DATA_W-1:0] hi;
        repeat (n) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            case ($urandom_range(9))
                4, 5, 6: hi = lo + 64'($urandom_range(300, 1));
                7:       hi = lo;
                8:       lo = '0;
                9:       hi = '1;
                default: ;
            endcase
            add_req(1'($urandom_range(1)), 2'($urandom_range(3)), lo, hi);
        end
    endtask

    task automatic wait_drained();
        while (draw_req_q.size() != 0 || s_axis_tvalid || exp_value_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [xrs_pkg::DATA_W-1:0] s);
        @(posedge i_clk);
        i_seed_we    <= 1'b1;
        i_seed_wdata <= s;
        @(posedge i_clk);
        i_seed_we    <= 1'b0;
        n_seeds++;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset seed
        add_req(xrs_pkg::MODE_RAW, xrs_pkg::WSEL_8, '0, '0);
        add_req(xrs_pkg::MODE_RAW, xrs_pkg::WSEL_16, '0, '0);
        add_req(xrs_pkg::MODE_RAW, xrs_pkg::WSEL_32, '0, '0);
        add_req(xrs_pkg::MODE_RAW, xrs_pkg::WSEL_64, '0, '0);
        add_req(xrs_pkg::MODE_RAW, xrs_pkg::WSEL_64, '1, '1);
        add_req(xrs_pkg::MODE_RAW, xrs_pkg::WSEL_8, '1, '0);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_8, '0, 64'hFF);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_16, '0, 64'hFFFF);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_32, '0, 64'hFFFF_FFFF);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_64, '0, '1);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_64, '1, '1);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_8, 64'd5, 64'd5);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_16, 64'h10, 64'h8);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_8, 64'h1FF, 64'h100);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_8, 64'hFFFF_FFFF_FFFF_FF10, 64'h20);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_32, 64'd7, 64'd8);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_64, '0, 64'd1);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_64, 64'h8000_0000_0000_0000, '1);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_16, 64'd100, 64'd103);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_64, 64'd1, 64'h8000_0000_0000_0000);
        add_req(xrs_pkg::MODE_BOUNDED, xrs_pkg::WSEL_32, 64'hABCD_0000_1234_5678,
                64'h1_FFFF_FFFF);
        wait_drained();

        // rewrite of the same seed restarts the sequence
        write_seed('0);
        add_random(200);
        wait_drained();

        write_seed('1);
        no_idle <= 1'b1;
        add_random(300);
        wait_drained();
        no_idle <= 1'b0;

        write_seed(64'h8000_0000_0000_0000);
        add_random(300);
        wait_drained();

        write_seed({$urandom, $urandom});
        add_random(300);
        wait_drained();

        write_seed({$urandom, $urandom});
        add_random(300);
        wait_drained();

        $display("checked %0d values: %0d raw, %0d bounded, %0d empty range",
                 n_checked, n_raw, n_bounded, n_empty);
        $display("seed writes after reset: %0d, mismatches: %0d", n_seeds, fail_count);
        if (fail_count == 0 && exp_value_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
